// ===== design/decimal_text_to_number_parser_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the decimal text parser
// Shared shorthand for clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TEXT_TO_NUMBER_PARSER_MACROS_SVH
`define DECIMAL_TEXT_TO_NUMBER_PARSER_MACROS_SVH

// Property checked at every rising clk edge, ignored while rst_n is low.
`define DTTN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication form: when cond holds, prop must hold in the same cycle.
`define DTTN_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

// ===== design/dttn_pkg.sv =====
// ----------------------------------------------------------------------------
// dttn_pkg
// Types, character codes and status codes shared by the parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dttn_pkg;

    localparam int MANT_W      = 60;
    localparam int FRAC_W      = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam logic [63:0] MANT_MASK = 64'h0FFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BLANK    = 3'd1,
        ST_POINT    = 3'd2,
        ST_BADCHAR  = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_MINUS,
        CLS_PLUS,
        CLS_POINT,
        CLS_DIGIT,
        CLS_BAD
    } char_class_t;

    // One classified character as it travels from front to back.
    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
        logic        last;
    } tok_t;

    // Largest mantissa allowed: 10^max_digits - 1, capped to 60 bits.
    function automatic logic [MANT_W-1:0] mant_limit(input int max_digits);
        logic [63:0] p;
        int          i;
        p = 64'd1;
        for (i = 0; i < 19; i++) begin
            if (i < max_digits) begin
                p = p * 64'd10;
            end
        end
        p = p - 64'd1;
        if (p > MANT_MASK) begin
            p = MANT_MASK;
        end
        return p[MANT_W-1:0];
    endfunction

endpackage

// ===== design/dttn_queue.sv =====
// ----------------------------------------------------------------------------
// dttn_queue
// Small register FIFO with valid/ready on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dttn_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/dttn_front.sv =====
// ----------------------------------------------------------------------------
// dttn_front
// Accepts characters and sorts each into a class for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dttn_front (
    input  logic          char_valid,
    output logic          char_ready,
    input  logic [7:0]    char_code,
    input  logic          last_char,
    output logic          tok_valid,
    input  logic          tok_ready,
    output dttn_pkg::tok_t tok
);

    import dttn_pkg::*;

    logic is_space;
    logic is_digit;

    assign char_ready = tok_ready;
    assign tok_valid  = char_valid;

    // Whitespace: space, and tab through carriage return.
    assign is_space = (char_code == CHAR_SPACE)
                   || ((char_code >= CHAR_TAB) && (char_code <= CHAR_CR));
    assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);

    always_comb begin
        tok.last  = last_char;
        tok.digit = char_code[3:0];   // '0'..'9' carry the value in the low nibble
        priority if (is_space) begin
            tok.cls = CLS_SPACE;
        end else if (is_digit) begin
            tok.cls = CLS_DIGIT;
        end else if (char_code == CHAR_MINUS) begin
            tok.cls = CLS_MINUS;
        end else if (char_code == CHAR_PLUS) begin
            tok.cls = CLS_PLUS;
        end else if (char_code == CHAR_POINT) begin
            tok.cls = CLS_POINT;
        end else begin
            tok.cls = CLS_BAD;
        end
    end

endmodule

// ===== design/dttn_back.sv =====
// ----------------------------------------------------------------------------
// dttn_back
// Parse state machine, digit accumulator and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dttn_back #(
    parameter int MAX_DIGITS = 18
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tok_valid,
    output logic                          tok_ready,
    input  dttn_pkg::tok_t                tok,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [2:0]                    status,
    output logic                          negative,
    output logic [dttn_pkg::MANT_W-1:0]   mantissa,
    output logic [dttn_pkg::FRAC_W-1:0]   frac_digits
);

    import dttn_pkg::*;

    localparam logic [MANT_W-1:0] LIMIT    = mant_limit(MAX_DIGITS);
    localparam logic [63:0]       LIMIT64  = 64'(LIMIT);
    localparam logic [FRAC_W-1:0] FRAC_MAX = FRAC_W'(MAX_DIGITS);

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_BODY,
        PH_TRAIL
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic              sign_reg, sign_next;
    logic              point_reg, point_next;
    logic [MANT_W-1:0] acc_reg, acc_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    status_t           err_reg, err_next;

    logic              res_valid_reg, res_valid_next;
    status_t           res_status_reg, res_status_next;
    logic              res_neg_reg, res_neg_next;
    logic [MANT_W-1:0] res_mant_reg, res_mant_next;
    logic [FRAC_W-1:0] res_frac_reg, res_frac_next;

    logic              take;
    logic              do_body;
    logic [63:0]       prod;
    status_t           fin_status;

    // A last item needs the result register free; others never wait.
    assign tok_ready = !tok.last || !res_valid_reg || result_ready;
    assign take      = tok_valid && tok_ready;

    assign result_valid = res_valid_reg;
    assign status       = res_status_reg;
    assign negative     = res_neg_reg;
    assign mantissa     = res_mant_reg;
    assign frac_digits  = res_frac_reg;

    // acc * 10 + digit as shift-adds; fits in 64 bits since acc < 2^60
    assign prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + 64'(tok.digit);

    always_comb begin
        phase_next = phase_reg;
        sign_next  = sign_reg;
        point_next = point_reg;
        acc_next   = acc_reg;
        frac_next  = frac_reg;
        err_next   = err_reg;
        do_body    = 1'b0;

        if (err_reg == ST_OK) begin
            unique case (phase_reg)
                PH_LEAD: begin
                    if (tok.cls != CLS_SPACE) begin
                        phase_next = PH_BODY;
                        if (tok.cls == CLS_MINUS) begin
                            sign_next = 1'b1;
                        end else if (tok.cls != CLS_PLUS) begin
                            do_body = 1'b1;
                        end
                    end
                end
                PH_BODY: begin
                    if (tok.cls == CLS_SPACE) begin
                        phase_next = PH_TRAIL;
                    end else begin
                        do_body = 1'b1;
                    end
                end
                PH_TRAIL: begin
                    if (tok.cls != CLS_SPACE) begin
                        err_next = ST_BADCHAR;
                    end
                end
                default: ;
            endcase
        end

        if (do_body) begin
            unique case (tok.cls)
                CLS_POINT: begin
                    if (point_reg) begin
                        err_next = ST_POINT;
                    end else begin
                        point_next = 1'b1;
                    end
                end
                CLS_DIGIT: begin
                    if (prod > LIMIT64) begin
                        err_next = ST_OVERFLOW;
                    end else if (point_reg && (frac_reg >= FRAC_MAX)) begin
                        err_next = ST_OVERFLOW;
                    end else begin
                        acc_next = prod[MANT_W-1:0];
                        if (point_reg) begin
                            frac_next = frac_reg + 1'b1;
                        end
                    end
                end
                default: err_next = ST_BADCHAR;
            endcase
        end

        fin_status = err_next;
        if ((err_next == ST_OK) && (phase_next == PH_LEAD)) begin
            fin_status = ST_BLANK;
        end

        res_valid_next  = res_valid_reg && !result_ready;
        res_status_next = res_status_reg;
        res_neg_next    = res_neg_reg;
        res_mant_next   = res_mant_reg;
        res_frac_next   = res_frac_reg;

        if (take && tok.last) begin
            res_valid_next  = 1'b1;
            res_status_next = fin_status;
            res_neg_next    = (fin_status == ST_OK) ? sign_next : 1'b0;
            res_mant_next   = (fin_status == ST_OK) ? acc_next : '0;
            res_frac_next   = (fin_status == ST_OK) ? frac_next : '0;
            // string done: back to the idle parse state
            phase_next = PH_LEAD;
            sign_next  = 1'b0;
            point_next = 1'b0;
            acc_next   = '0;
            frac_next  = '0;
            err_next   = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg      <= PH_LEAD;
            sign_reg       <= 1'b0;
            point_reg      <= 1'b0;
            acc_reg        <= '0;
            frac_reg       <= '0;
            err_reg        <= ST_OK;
            res_valid_reg  <= 1'b0;
            res_status_reg <= ST_OK;
            res_neg_reg    <= 1'b0;
            res_mant_reg   <= '0;
            res_frac_reg   <= '0;
        end else begin
            if (take) begin
                phase_reg <= phase_next;
                sign_reg  <= sign_next;
                point_reg <= point_next;
                acc_reg   <= acc_next;
                frac_reg  <= frac_next;
                err_reg   <= err_next;
            end
            res_valid_reg  <= res_valid_next;
            res_status_reg <= res_status_next;
            res_neg_reg    <= res_neg_next;
            res_mant_reg   <= res_mant_next;
            res_frac_reg   <= res_frac_next;
        end
    end

endmodule

// ===== design/decimal_text_to_number_parser.sv =====
// ----------------------------------------------------------------------------
// decimal_text_to_number_parser
// Streams ASCII characters in, one result per string out.
// ----------------------------------------------------------------------------
// The block takes one character per cycle on the char channel while
// char_ready is high, the last one of a string marked by last_char, and
// returns one result per string: status, sign, the digits as one decimal
// integer (mantissa) and the count of digits after the point, so value =
// +/- mantissa / 10^frac_digits. Leading and trailing whitespace (tab..CR,
// space) is skipped; an optional sign comes first, then digits with at most
// one point. Status codes: 0 ok, 1 only whitespace, 2 second point, 3 bad
// character, 4 overflow (more than MAX_DIGITS digits of value, or more than
// MAX_DIGITS fraction digits). On any error status the other fields read
// zero. The first error in a string wins; later characters are ignored up
// to the marked last one. Throughput is one character per cycle while the
// input is not stalled; it is set by the back end's per-character step, one
// multiply-by-ten-and-add on the 60-bit accumulator with its limit compare.
// A result appears on the output the cycle after its last character is
// taken by the back end; an accepted character passes through the queue and
// then into the result register. The front classifies characters and feeds
// a two-item queue; the back end holds a result register, so input keeps
// flowing while a result waits, stalling only when a second last character
// arrives before the pending result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module decimal_text_to_number_parser #(
    parameter int MAX_DIGITS = 18
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // character channel
    input  logic                        char_valid,
    output logic                        char_ready,
    input  logic [7:0]                  char_code,
    input  logic                        last_char,
    // result channel
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic [2:0]                  status,
    output logic                        negative,
    output logic [dttn_pkg::MANT_W-1:0] mantissa,
    output logic [dttn_pkg::FRAC_W-1:0] frac_digits
);

    import dttn_pkg::*;

    // classified item, front to queue
    logic front_valid;
    logic front_ready;
    tok_t front_tok;

    // queue to back end
    logic back_valid;
    logic back_ready;
    tok_t back_tok;

    dttn_front u_front (
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_code  (char_code),
        .last_char  (last_char),
        .tok_valid  (front_valid),
        .tok_ready  (front_ready),
        .tok        (front_tok)
    );

    dttn_queue #(
        .WIDTH ($bits(tok_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_tok),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_tok)
    );

    dttn_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_valid    (back_valid),
        .tok_ready    (back_ready),
        .tok          (back_tok),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .negative     (negative),
        .mantissa     (mantissa),
        .frac_digits  (frac_digits)
    );

endmodule

// ===== design/dttn_checker.sv =====
// ----------------------------------------------------------------------------
// dttn_checker
// Port-level assertions for the decimal text parser, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "decimal_text_to_number_parser_macros.svh"

module dttn_checker #(
    parameter int MAX_DIGITS = 18
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        char_valid,
    input logic                        char_ready,
    input logic [7:0]                  char_code,
    input logic                        last_char,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic [2:0]                  status,
    input logic                        negative,
    input logic [dttn_pkg::MANT_W-1:0] mantissa,
    input logic [dttn_pkg::FRAC_W-1:0] frac_digits
);

    import dttn_pkg::*;

    localparam logic [FRAC_W-1:0] FRAC_MAX = FRAC_W'(MAX_DIGITS);
    localparam logic [MANT_W-1:0] LIMIT    = mant_limit(MAX_DIGITS);

    // a pending result holds its payload until taken
    `DTTN_ASSERT(a_result_hold, (result_valid && !result_ready) |=> (result_valid && $stable(status) && $stable(mantissa) && $stable(frac_digits) && $stable(negative)), "result changed while stalled")

    // error results carry zero fields
    `DTTN_ASSERT_IMPL(a_err_zero, result_valid && (status != ST_OK), (!negative && (mantissa == '0) && (frac_digits == '0)), "error result with nonzero fields")

    // status is one of the defined codes
    `DTTN_ASSERT_IMPL(a_status_code, result_valid, ((status == ST_OK) || (status == ST_BLANK) || (status == ST_POINT) || (status == ST_BADCHAR) || (status == ST_OVERFLOW)), "undefined status code")

    // ok results stay within digit limits
    `DTTN_ASSERT_IMPL(a_ok_range, result_valid && (status == ST_OK), ((frac_digits <= FRAC_MAX) && (mantissa <= LIMIT)), "ok result out of range")

endmodule

bind decimal_text_to_number_parser dttn_checker #(.MAX_DIGITS(MAX_DIGITS)) u_dttn_checker (.*);

// ===== dv/decimal_text_to_number_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_number_parser_tb
// Streams character items into the parser and checks each parsed number.
// ----------------------------------------------------------------------------
// A short table of strings comes first: whitespace-only strings, bare signs
// and points, the largest mantissa, the longest fraction, both overflow
// kinds, a second point, misplaced signs, inner whitespace and high codes.
// Random strings follow. Most are well-formed numbers with random content,
// some are broken on purpose, and the rest are whitespace or raw bytes.
// Each accepted character goes through a local parse model. A marked last
// character yields one expected number, and every result the block returns
// is compared field by field with the oldest one waiting.
// ----------------------------------------------------------------------------

module decimal_text_to_number_parser_tb;

    import dttn_pkg::*;

    localparam int          DIGITS       = 18;
    localparam logic [59:0] MANT_MAX     = 60'd999_999_999_999_999_999;
    localparam int          RANDOM_ITEMS = 1830;
    localparam int          QUIET_TAIL   = 300;   // last items run without gaps
    localparam int          LONG_HOLD    = 60;    // receiver hold-off, cycles
    localparam int          NUM_ROWS     = 20;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_BODY,
        PH_TRAIL
    } parse_phase_t;

    typedef struct packed {
        status_t     st;
        logic        neg;
        logic [59:0] mant;
        logic [4:0]  frac;
    } number_t;

    typedef struct packed {
        logic    typed;     // 1: the expected number is given in the table
        number_t num;
    } row_expect_t;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        char_valid;
    logic        char_ready;
    logic [7:0]  char_code;
    logic        last_char;
    logic        result_valid;
    logic        result_ready;
    logic [2:0]  status;
    logic        negative;
    logic [59:0] mantissa;
    logic [4:0]  frac_digits;

    decimal_text_to_number_parser #(
        .MAX_DIGITS(DIGITS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .char_code   (char_code),
        .last_char   (last_char),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .status      (status),
        .negative    (negative),
        .mantissa    (mantissa),
        .frac_digits (frac_digits)
    );

    // ------------------------------------------------------------------
    // Parse model state; it returns to these values after each string
    // ------------------------------------------------------------------
    parse_phase_t ph         = PH_LEAD;
    logic         minus_seen = 1'b0;
    logic         got_point  = 1'b0;
    logic [59:0]  acc        = '0;
    logic [4:0]   nfrac      = '0;
    status_t      fault      = ST_OK;

    number_t      expected_numbers[$];
    logic [7:0]   text_buf[$];

    int           mismatches = 0;
    int           chars_sent = 0;
    bit           gaps_on    = 1'b1;
    bit           hold_req   = 1'b0;

    // Directed strings. "\015" is carriage return; "\377" and "\200" are the
    // codes 255 and 128.
    string row_text [NUM_ROWS] = '{
        " ",
        "\t\015",
        "-",
        "+",
        ".",
        "-.",
        "-0",
        "999999999999999999",
        "9999999999999999999",
        ".000000000000000000",
        ".0000000000000000000",
        "1.2.3",
        "..x",
        "1-",
        " 1 2",
        "\377",
        "\200",
        "9:",
        " +12.50 ",
        "-3.14159\t"
    };

    row_expect_t row_expect [NUM_ROWS] = '{
        '{1'b1, '{ST_BLANK,    1'b0, 60'd0,   5'd0}},
        '{1'b1, '{ST_BLANK,    1'b0, 60'd0,   5'd0}},
        '{1'b1, '{ST_OK,       1'b1, 60'd0,   5'd0}},
        '{1'b1, '{ST_OK,       1'b0, 60'd0,   5'd0}},
        '{1'b1, '{ST_OK,       1'b0, 60'd0,   5'd0}},
        '{1'b1, '{ST_OK,       1'b1, 60'd0,   5'd0}},
        '{1'b1, '{ST_OK,       1'b1, 60'd0,   5'd0}},
        '{1'b1, '{ST_OK,       1'b0, MANT_MAX, 5'd0}},
        '{1'b1, '{ST_OVERFLOW, 1'b0, 60'd0,   5'd0}},
        '{1'b1, '{ST_OK,       1'b0, 60'd0,   5'd18}},
        '{1'b1, '{ST_OVERFLOW, 1'b0, 60'd0,   5'd0}},
        '{1'b1, '{ST_POINT,    1'b0, 60'd0,   5'd0}},
        '{1'b1, '{ST_POINT,    1'b0, 60'd0,   5'd0}},
        '{1'b1, '{ST_BADCHAR,  1'b0, 60'd0,   5'd0}},
        '{1'b1, '{ST_BADCHAR,  1'b0, 60'd0,   5'd0}},
        '{1'b1, '{ST_BADCHAR,  1'b0, 60'd0,   5'd0}},
        '{1'b1, '{ST_BADCHAR,  1'b0, 60'd0,   5'd0}},
        '{1'b1, '{ST_BADCHAR,  1'b0, 60'd0,   5'd0}},
        '{1'b0, '0},
        '{1'b0, '0}
    };

    // ------------------------------------------------------------------
    // Clock, reset, run limit
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Parse model
    // ------------------------------------------------------------------
    function automatic logic is_blank(input logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    // Digit, point or anything else once the number body has started.
    function automatic void take_body_char(input logic [7:0] c);
        logic [63:0] d;
        if (c == CHAR_POINT) begin
            if (got_point)
                fault = ST_POINT;
            else
                got_point = 1'b1;
        end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = 64'(c - CHAR_ZERO);
            // overflow when acc*10+d would pass the largest mantissa
            if (64'(acc) > (64'(MANT_MAX) - d) / 64'd10)
                fault = ST_OVERFLOW;
            else if (got_point && nfrac == 5'(DIGITS))
                fault = ST_OVERFLOW;
            else begin
                if (got_point)
                    nfrac = nfrac + 5'd1;
                acc = 60'(64'(acc) * 64'd10 + d);
            end
        end else begin
            fault = ST_BADCHAR;
        end
    endfunction

    // One accepted character; on the last one, the number it completes.
    function automatic void digest_char(input logic [7:0] c, input logic last,
                                        output number_t res);
        res = '0;
        // first error wins: nothing moves until the end of the string
        if (fault == ST_OK) begin
            case (ph)
                PH_LEAD:
                    if (!is_blank(c)) begin
                        ph = PH_BODY;
                        if (c == CHAR_MINUS)
                            minus_seen = 1'b1;
                        else if (c != CHAR_PLUS)
                            take_body_char(c);
                    end
                PH_BODY:
                    if (is_blank(c))
                        ph = PH_TRAIL;
                    else
                        take_body_char(c);
                default:
                    if (!is_blank(c))
                        fault = ST_BADCHAR;
            endcase
        end
        if (last) begin
            res.st = fault;
            if (fault == ST_OK && ph == PH_LEAD)
                res.st = ST_BLANK;
            if (res.st == ST_OK) begin
                res.neg  = minus_seen;
                res.mant = acc;
                res.frac = nfrac;
            end
            ph         = PH_LEAD;
            minus_seen = 1'b0;
            got_point  = 1'b0;
            acc        = '0;
            nfrac      = '0;
            fault      = ST_OK;
        end
    endfunction

    // ------------------------------------------------------------------
    // Character channel
    // ------------------------------------------------------------------
    // Drives one item at the falling edge, optionally after a short gap,
    // and holds it until accepted. A typed number replaces the model's.
    task automatic send_char(input logic [7:0] c, input logic last,
                             input logic use_typed, input number_t typed);
        int      gap;
        number_t res;
        gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        @(negedge clk);
        if (gap > 0) begin
            char_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_valid <= 1'b1;
        char_code  <= c;
        last_char  <= last;
        do @(posedge clk); while (!char_ready);
        chars_sent++;
        digest_char(c, last, res);
        if (last)
            expected_numbers.push_back(use_typed ? typed : res);
    endtask

    function automatic logic [7:0] pick_blank();
        return ($urandom_range(0, 5) == 0) ? CHAR_SPACE
                                           : 8'($urandom_range(CHAR_TAB, CHAR_CR));
    endfunction

    // Long numbers lean on nines and zeros to hit both overflow kinds.
    function automatic logic [7:0] pick_digit(input bit lengthy);
        if (lengthy && $urandom_range(0, 2) != 0)
            return $urandom_range(0, 1) ? CHAR_NINE : CHAR_ZERO;
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Fills text_buf with one random string.
    task automatic build_random_text();
        int kind;
        int n_int;
        int n_frac;
        int pos;
        bit lengthy;
        bit with_point;
        text_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
            repeat ($urandom_range(0, 2)) text_buf.push_back(pick_blank());
            case ($urandom_range(0, 3))
                0:       text_buf.push_back(CHAR_MINUS);
                1:       text_buf.push_back(CHAR_PLUS);
                default: ;
            endcase
            lengthy    = ($urandom_range(0, 9) == 0);
            with_point = ($urandom_range(0, 2) != 0);
            n_int      = lengthy ? $urandom_range(0, 19) : $urandom_range(0, 6);
            n_frac     = !with_point ? 0 :
                         lengthy ? $urandom_range(0, 19) : $urandom_range(0, 5);
            repeat (n_int) text_buf.push_back(pick_digit(lengthy));
            if (with_point) begin
                text_buf.push_back(CHAR_POINT);
                repeat (n_frac) text_buf.push_back(pick_digit(lengthy));
            end
            repeat ($urandom_range(0, 2)) text_buf.push_back(pick_blank());
            if (text_buf.size() == 0)
                text_buf.push_back(pick_digit(1'b0));
            // broken sequence: one stray character somewhere in the string
            if (kind >= 65) begin
                pos = $urandom_range(0, text_buf.size() - 1);
                case ($urandom_range(0, 3))
                    0:       text_buf[pos] = 8'($urandom_range(0, 255));
                    1:       text_buf.insert(pos, CHAR_POINT);
                    2:       text_buf.insert(pos, $urandom_range(0, 1) ? CHAR_MINUS
                                                                        : CHAR_PLUS);
                    default: text_buf.insert(pos, pick_blank());
                endcase
            end
        end else if (kind < 88) begin
            repeat ($urandom_range(1, 4)) text_buf.push_back(pick_blank());
        end else begin
            repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Result channel: short random stalls, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int stall_cnt;
        stall_cnt    = 0;
        result_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                stall_cnt = LONG_HOLD;
            end else if (stall_cnt == 0 && gaps_on && $urandom_range(0, 4) == 0) begin
                stall_cnt = $urandom_range(1, 3);
            end
            if (stall_cnt > 0) begin
                result_ready <= 1'b0;
                stall_cnt--;
            end else begin
                result_ready <= 1'b1;
            end
        end
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    // Compare each accepted result with the oldest expected number.
    always @(posedge clk) begin
        number_t want;
        if (rst_n && result_valid && result_ready) begin
            if (expected_numbers.size() == 0) begin
                report_mismatch("result with none pending, status", 64'(status), 64'd0);
            end else begin
                want = expected_numbers.pop_front();
                if (status !== want.st)
                    report_mismatch("status", 64'(status), 64'(want.st));
                if (negative !== want.neg)
                    report_mismatch("negative", 64'(negative), 64'(want.neg));
                if (mantissa !== want.mant)
                    report_mismatch("mantissa", 64'(mantissa), 64'(want.mant));
                if (frac_digits !== want.frac)
                    report_mismatch("frac_digits", 64'(frac_digits), 64'(want.frac));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int     strings_sent;
        int     r;
        int     k;
        int     len;
        rst_n      = 1'b0;
        char_valid = 1'b0;
        char_code  = '0;
        last_char  = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (r = 0; r < NUM_ROWS; r++) begin
            len = row_text[r].len();
            for (k = 0; k < len; k++)
                send_char(row_text[r][k], k == len - 1, row_expect[r].typed,
                          row_expect[r].num);
        end

        // random strings; a few long receiver hold-offs fill the block
        chars_sent   = 0;
        strings_sent = 0;
        while (chars_sent < RANDOM_ITEMS) begin
            gaps_on = (chars_sent < RANDOM_ITEMS - QUIET_TAIL) &&
                      ((chars_sent / 150) % 4 != 3);
            if (strings_sent == 10 || strings_sent == 200)
                hold_req = 1'b1;
            build_random_text();
            for (k = 0; k < text_buf.size(); k++)
                send_char(text_buf[k], k == text_buf.size() - 1, 1'b0, '0);
            strings_sent++;
        end

        @(negedge clk);
        char_valid <= 1'b0;
        while (expected_numbers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
